// ===== src/lcf_pkg.sv =====
// Shared types and constants of the line command forwarder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lcf_pkg;

	localparam int ROW_BYTES   = 64;
	localparam int COL_W       = $clog2(ROW_BYTES);
	localparam int PREFIX_LEN  = 13;
	localparam int MATCH_W     = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [7:0] NEWLINE    = 8'h0A;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_END     = 2'd1,
		KIND_INVALID = 2'd2
	} kind_t;

	// one queue entry: the first result of a byte, plus a flag for a trailing end marker
	typedef struct packed {
		kind_t      kind;
		logic [7:0] dest;
		logic [7:0] data;
		logic       two;
	} action_t;

	function automatic logic [7:0] prefix_byte(input logic [MATCH_W-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = 8'h24;
			4'd1:    b = 8'h66;
			4'd2:    b = 8'h77;
			4'd3:    b = 8'h64;
			4'd4:    b = 8'h2D;
			4'd5:    b = 8'h6C;
			4'd6:    b = 8'h61;
			4'd7:    b = 8'h65;
			4'd8:    b = 8'h6C;
			4'd9:    b = 8'h61;
			4'd10:   b = 8'h70;
			4'd11:   b = 8'h73;
			4'd12:   b = 8'h2D;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== src/lcf_front.sv =====
// Front end: takes bytes, tracks line position and prefix match, classifies each
// byte into an entry or none. Holds the dest_count register. Depends on lcf_pkg.
`default_nettype none

module lcf_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       rx_byte,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [3:0]       cfg_data,
	input  wire logic             q_full,
	output logic                  q_push,
	output lcf_pkg::action_t      q_entry
);
	import lcf_pkg::*;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_DIGIT,
		PH_SKIP,
		PH_FORWARD,
		PH_DONE
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [COL_W-1:0]   col_q, col_n;
	logic [MATCH_W-1:0] mp_q, mp_n;
	logic [3:0]         target_q, target_n;
	logic               ended_q, ended_n;
	logic [3:0]         dest_count_q;
	logic               accept, line_end, emit;
	logic [7:0]         digit;

	assign in_stall  = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign digit     = rx_byte - DIGIT_BASE;

	always_comb begin
		phase_n  = phase_q;
		mp_n     = mp_q;
		target_n = target_q;
		ended_n  = ended_q;
		col_n    = col_q;
		emit     = 1'b0;
		q_entry  = '{kind: KIND_DATA, dest: {4'd0, target_q}, data: 8'd0, two: 1'b0};

		if (rx_byte == NEWLINE) begin
			line_end = 1'b1;
		end else begin
			col_n    = col_q + 1'b1;
			line_end = col_n >= COL_W'(ROW_BYTES - 1);
		end

		unique case (phase_q)
			PH_SEARCH: begin
				if (!ended_q) begin
					if (rx_byte == 8'd0) begin
						ended_n = 1'b1;
					end else begin
						if (rx_byte == prefix_byte(mp_q))
							mp_n = mp_q + 1'b1;
						else
							mp_n = (rx_byte == prefix_byte('0)) ? MATCH_W'(1) : '0;
						if (mp_n >= MATCH_W'(PREFIX_LEN)) begin
							phase_n = PH_DIGIT;
							// line full right after the prefix: digit reads as zero
							if (line_end) begin
								emit         = 1'b1;
								q_entry.kind = KIND_INVALID;
								q_entry.dest = 8'd0 - DIGIT_BASE;
							end
						end
					end
				end
			end
			PH_DIGIT: begin
				if (digit < {4'd0, dest_count_q}) begin
					target_n = digit[3:0];
					phase_n  = PH_SKIP;
					if (line_end) begin
						emit         = 1'b1;
						q_entry.kind = KIND_END;
						q_entry.dest = digit;
					end
				end else begin
					phase_n      = PH_DONE;
					emit         = 1'b1;
					q_entry.kind = KIND_INVALID;
					q_entry.dest = digit;
				end
			end
			PH_SKIP: begin
				phase_n = PH_FORWARD;
				if (line_end) begin
					emit         = 1'b1;
					q_entry.kind = KIND_END;
				end
			end
			PH_FORWARD: begin
				if (!ended_q && rx_byte == 8'd0) begin
					ended_n = 1'b1;
					if (line_end) begin
						emit         = 1'b1;
						q_entry.kind = KIND_END;
					end
				end else if (!ended_q) begin
					emit         = 1'b1;
					q_entry.data = rx_byte;
					q_entry.two  = line_end;
				end else if (line_end) begin
					emit         = 1'b1;
					q_entry.kind = KIND_END;
				end
			end
			PH_DONE: ;
			default: ;
		endcase
	end

	assign q_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SEARCH;
			col_q        <= '0;
			mp_q         <= '0;
			target_q     <= '0;
			ended_q      <= 1'b0;
			dest_count_q <= 4'd5;
		end else begin
			if (cfg_valid && cfg_ready)
				dest_count_q <= cfg_data;
			if (accept) begin
				if (line_end) begin
					phase_q  <= PH_SEARCH;
					col_q    <= '0;
					mp_q     <= '0;
					target_q <= '0;
					ended_q  <= 1'b0;
				end else begin
					phase_q  <= phase_n;
					col_q    <= col_n;
					mp_q     <= mp_n;
					target_q <= target_n;
					ended_q  <= ended_n;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/lcf_queue.sv =====
// Short FIFO of classified items between front and back end.
// Flip-flop storage, depth from lcf_pkg. Depends on lcf_pkg.
`default_nettype none

module lcf_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lcf_pkg::action_t push_entry,
	input  wire logic             pop,
	output lcf_pkg::action_t      head,
	output logic                  empty,
	output logic                  full
);
	import lcf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	action_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   count_q;

	assign empty = count_q == '0;
	assign full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/lcf_back.sv =====
// Back end: expands queue entries into one or two results and drives the
// registered output channel. Depends on lcf_pkg.
`default_nettype none

module lcf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lcf_pkg::action_t head,
	input  wire logic             q_empty,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            kind,
	output logic [7:0]            destination,
	output logic [7:0]            data,
	output logic                  last_of_item
);
	import lcf_pkg::*;

	logic  load, second_q;
	kind_t kind_q;

	assign load  = !out_valid || !out_stall;
	// a two-result entry stays at the head until its end marker goes out
	assign q_pop = load && !q_empty && (second_q || !head.two);
	assign kind  = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			second_q  <= 1'b0;
		end else if (load) begin
			out_valid <= !q_empty;
			if (!q_empty)
				second_q <= !second_q && head.two;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			destination <= head.dest;
			if (second_q) begin
				kind_q       <= KIND_END;
				data         <= 8'd0;
				last_of_item <= 1'b1;
			end else begin
				kind_q       <= head.kind;
				data         <= head.data;
				last_of_item <= !head.two;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/line_command_forwarder.sv =====
// Each result passes through the item queue and then the output register.
// One byte per cycle in; one result per cycle out while out_stall is low, set by the
// single output register, so a forwarded newline and its end marker go out in turn.
// The front stalls input only when the four-entry item queue is full.
// Reset (arst_n low, asynchronous): line state cleared, queue empty, dest_count = 5.
// Depends on lcf_pkg, lcf_front, lcf_queue, lcf_back.
`default_nettype none

module line_command_forwarder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      destination,
	output logic [7:0]      data,
	output logic            last_of_item
);
	import lcf_pkg::*;

	action_t push_entry, head;
	logic    push, pop, q_empty, q_full;

	lcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (push),
		.q_entry   (push_entry)
	);

	lcf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	lcf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.destination  (destination),
		.data         (data),
		.last_of_item (last_of_item)
	);

endmodule

`default_nettype wire

// ===== src/lcf_checker.sv =====
// Port-level checks for line_command_forwarder, attached by bind.
// Depends on lcf_pkg and the top level's ports.
`default_nettype none

module lcf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] kind,
	input wire logic [7:0] destination,
	input wire logic [7:0] data,
	input wire logic       last_of_item
);
	import lcf_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(destination)
			&& $stable(data) && $stable(last_of_item))
		else $error("stalled result changed");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_DATA || kind == KIND_END || kind == KIND_INVALID)
		else $error("undefined result kind");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> data == 8'd0)
		else $error("non-payload result carries data");

	// only a payload byte can have a trailing end marker, and it follows at once
	a_end_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_item |=>
			out_valid && kind == KIND_END && last_of_item && destination == $past(destination))
		else $error("end marker missing after payload byte");

endmodule

bind line_command_forwarder lcf_checker u_lcf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.destination  (destination),
	.data         (data),
	.last_of_item (last_of_item)
);

`default_nettype wire

// ===== dv/line_command_forwarder_test.sv =====
// Self-checking testbench for line_command_forwarder: byte stream in, forwarded items out.
// Holds its own line-splitting and command-matching predictor; depends on lcf_pkg and the RTL.
`timescale 1ns / 100ps

module line_command_forwarder_test;
	import lcf_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int DRAIN_CYCLES = 10;
	localparam int IDLE_PERCENT = 18;
	localparam int REPORT_LIMIT = 10;

	// command word, first byte in the top bits
	localparam logic [8*PREFIX_LEN-1:0] CMD_WORD = 104'h24667764_2D6C6165_6C617073_2D;
	localparam logic [7:0] ZERO_DIGIT_ADDR = 8'h00 - DIGIT_BASE;

	typedef enum logic [2:0] {
		SEEK_PREFIX,
		READ_DIGIT,
		SKIP_ONE,
		FORWARD_TEXT,
		LINE_DONE
	} line_phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] dest;
		logic [7:0] data;
		logic       last;
	} fwd_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_data = 4'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] destination;
	logic [7:0] data;
	logic       last_of_item;

	// predictor state
	logic [3:0]  dest_limit = 4'd5;
	logic [7:0]  col_count = 8'd0;
	line_phase_t line_phase = SEEK_PREFIX;
	int          match_pos = 0;
	logic [3:0]  target = 4'd0;
	logic        text_done = 1'b0;

	fwd_result_t pending_results[$];

	bit quiet = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int held_cycles = 0;
	int items_sent = 0;
	int cfg_writes = 0;
	int failures = 0;
	int results_seen = 0;
	int kind_seen[3] = '{0, 0, 0};

	line_command_forwarder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.destination (destination),
		.data        (data),
		.last_of_item(last_of_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] cmd_byte(input int i);
		return CMD_WORD[8*(PREFIX_LEN-1-i) +: 8];
	endfunction

	function automatic void restart_line();
		col_count = 8'd0;
		line_phase = SEEK_PREFIX;
		match_pos = 0;
		target = 4'd0;
		text_done = 1'b0;
	endfunction

	// expected items caused by one accepted byte
	task automatic route_byte(input logic [7:0] b);
		fwd_result_t made[2];
		int n;
		logic line_end;
		logic [7:0] addr;
		n = 0;
		if (b == NEWLINE) begin
			line_end = 1'b1;
		end else begin
			col_count = col_count + 8'd1;
			line_end = (col_count >= ROW_BYTES - 1);
		end
		addr = b - DIGIT_BASE;
		case (line_phase)
			SEEK_PREFIX: begin
				if (!text_done) begin
					if (b == 8'h00) begin
						text_done = 1'b1;
					end else begin
						if (match_pos < PREFIX_LEN && b == cmd_byte(match_pos))
							match_pos++;
						else
							match_pos = (b == cmd_byte(0)) ? 1 : 0;
						if (match_pos >= PREFIX_LEN) begin
							line_phase = READ_DIGIT;
							// line full right after the prefix: digit reads as zero
							if (line_end) begin
								made[n] = '{KIND_INVALID, ZERO_DIGIT_ADDR, 8'h00, 1'b0};
								n++;
							end
						end
					end
				end
			end
			READ_DIGIT: begin
				if (addr < dest_limit) begin
					target = addr[3:0];
					line_phase = SKIP_ONE;
					if (line_end) begin
						made[n] = '{KIND_END, {4'h0, target}, 8'h00, 1'b0};
						n++;
					end
				end else begin
					line_phase = LINE_DONE;
					made[n] = '{KIND_INVALID, addr, 8'h00, 1'b0};
					n++;
				end
			end
			SKIP_ONE: begin
				line_phase = FORWARD_TEXT;
				if (line_end) begin
					made[n] = '{KIND_END, {4'h0, target}, 8'h00, 1'b0};
					n++;
				end
			end
			FORWARD_TEXT: begin
				if (!text_done) begin
					if (b == 8'h00) begin
						text_done = 1'b1;
					end else begin
						made[n] = '{KIND_DATA, {4'h0, target}, b, 1'b0};
						n++;
					end
				end
				if (line_end) begin
					made[n] = '{KIND_END, {4'h0, target}, 8'h00, 1'b0};
					n++;
				end
			end
			default: ;
		endcase
		if (n > 0)
			made[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			pending_results.push_back(made[k]);
		if (line_end)
			restart_line();
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			route_byte(rx_byte);
	end

	always @(posedge clk) begin : check_results
		fwd_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				if (failures < REPORT_LIMIT)
					$display("unexpected item: kind %0d dest %02h data %02h last %0b",
						kind, destination, data, last_of_item);
				failures++;
			end else begin
				want = pending_results.pop_front();
				kind_seen[want.kind]++;
				if (kind !== want.kind || destination !== want.dest || data !== want.data
						|| last_of_item !== want.last) begin
					if (failures < REPORT_LIMIT) begin
						$display("mismatch on item %0d: expected kind %0d dest %02h data %02h last %0b",
							results_seen, want.kind, want.dest, want.data, want.last);
						$display("    got kind %0d dest %02h data %02h last %0b",
							kind, destination, data, last_of_item);
					end
					failures++;
				end
			end
		end
	end

	// receiver: random stalls, or a counted hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (in_valid && in_stall)
			held_cycles++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still expected",
				cycle_count, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			@(posedge clk);
		end
	endtask

	task automatic send_prefix();
		for (int i = 0; i < PREFIX_LEN; i++)
			send_byte(cmd_byte(i));
	endtask

	// random byte that is never a newline, sometimes zero
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		if ($urandom_range(0, 99) < 5)
			return 8'h00;
		b = 8'($urandom);
		if (b == NEWLINE)
			b = 8'h0B;
		return b;
	endfunction

	// block may still be busy on bytes that give no item
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_dest_count(input logic [3:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dest_limit = v;
		cfg_writes++;
	endtask

	task automatic send_random_line();
		logic [7:0] line[$];
		logic [7:0] b;
		int shape;
		int lead;
		int plen;
		int r;
		shape = $urandom_range(0, 99);
		if (shape < 12) begin
			plen = $urandom_range(0, 70);
			repeat (plen) line.push_back(8'($urandom));
			line.push_back(NEWLINE);
		end else begin
			// long leads put the prefix, digit or skipped byte on the last column
			lead = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(44, 52);
			repeat (lead) line.push_back(text_byte());
			if ($urandom_range(0, 99) < 10) begin
				plen = $urandom_range(1, PREFIX_LEN - 1);
				for (int i = 0; i < plen; i++)
					line.push_back(cmd_byte(i));
			end
			for (int i = 0; i < PREFIX_LEN; i++) begin
				b = cmd_byte(i);
				if ($urandom_range(0, 99) < 3)
					b = text_byte();
				line.push_back(b);
			end
			r = $urandom_range(0, 99);
			if (r < 70)
				line.push_back(DIGIT_BASE + 8'($urandom_range(0, 15)));
			else if (r < 85)
				line.push_back(8'($urandom));
			else if (r < 92)
				line.push_back(8'h00);
			else
				line.push_back(NEWLINE);
			line.push_back(($urandom_range(0, 99) < 92) ? text_byte() : NEWLINE);
			if ($urandom_range(0, 99) < 15) begin
				while (line.size() < ROW_BYTES - 1)
					line.push_back(text_byte());
			end else begin
				plen = $urandom_range(0, 10);
				repeat (plen) line.push_back(text_byte());
				line.push_back(NEWLINE);
			end
		end
		foreach (line[k])
			send_byte(line[k]);
	endtask

	task automatic run_random_lines(input int n_items);
		int start;
		start = items_sent;
		while (items_sent - start < n_items)
			send_random_line();
	endtask

	task automatic test_byte_extremes();
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(NEWLINE);
	endtask

	// skipped zero, zero ending the payload, trailing bytes dropped
	task automatic test_forward_command();
		send_prefix();
		send_byte(DIGIT_BASE + 8'd4);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h41);
		send_byte(NEWLINE);
	endtask

	task automatic test_invalid_zero_digit();
		send_prefix();
		send_byte(8'h00);
		send_byte(NEWLINE);
	endtask

	task automatic test_dest_count_sweep();
		logic [3:0] sweep[4];
		sweep = '{4'd1, 4'd10, 4'd0, 4'd15};
		foreach (sweep[i]) begin
			set_dest_count(sweep[i]);
			run_random_lines(120);
		end
	endtask

	task automatic test_quiet_stretch();
		set_dest_count(4'd5);
		quiet = 1'b1;
		run_random_lines(220);
		quiet = 1'b0;
	endtask

	// receiver holds off while a long payload keeps coming; the block must stall its input
	task automatic test_backpressure();
		set_dest_count(4'd9);
		quiet = 1'b1;
		hold_left = 300;
		send_prefix();
		send_byte(DIGIT_BASE + 8'd8);
		send_byte(8'h20);
		repeat (40) send_byte(8'($urandom_range(1, 255)) | 8'h80);
		send_byte(NEWLINE);
		quiet = 1'b0;
	endtask

	task automatic test_random_settings();
		repeat (2) begin
			set_dest_count(4'($urandom_range(0, 15)));
			run_random_lines(100);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_byte_extremes();
		test_forward_command();
		test_invalid_zero_digit();
		test_dest_count_sweep();
		test_quiet_stretch();
		test_backpressure();
		test_random_settings();
		wait_drained();
		$display("%0d bytes in, %0d items out: %0d payload, %0d end, %0d invalid",
			items_sent, results_seen, kind_seen[KIND_DATA], kind_seen[KIND_END],
			kind_seen[KIND_INVALID]);
		$display("%0d dest_count writes, input held off for %0d cycles, %0d failures",
			cfg_writes, held_cycles, failures);
		if (failures == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
